// ===== rtl/wpsc_pkg.sv =====
// ----------------------------------------------------------------------------
// wpsc_pkg
// Shared widths, reset values and controller/datapath interface types for
// the sliding-window pair-sum checker.
// ----------------------------------------------------------------------------
package wpsc_pkg;

    // Value width and config register width
    localparam int DATA_W     = 64;
    localparam int CFG_W      = 6;
    // One bit wider than the config register so it compares against MAX_WINDOW
    localparam int LEN_CMP_W  = CFG_W + 1;

    localparam logic [CFG_W-1:0] WINDOW_LEN_RST = 6'd25;
    localparam int               MAX_WINDOW_DEF = 32;
    localparam int               MIN_WINDOW     = 2;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // capture input transaction
        logic scan_init;  // set up pair pointers and clear match flag
        logic scan_step;  // read one pair and advance pointers
        logic commit;     // store value in window, advance slot and fill
        logic out_load;   // load result into output register
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic check;      // window holds enough values to check this one
        logic scan_last;  // current pair is the last of the scan
        logic out_free;   // output register can take a result this cycle
    } t_sts;

endpackage

// ===== rtl/wpsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// wpsc_ctrl
// Sequencer for the pair-sum checker: accepts one transaction, stores a
// preamble value at once, or walks all window pairs through the datapath,
// then stores the value and hands off the result.
// ----------------------------------------------------------------------------
module wpsc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  wpsc_pkg::t_sts i_sts,
    output wpsc_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_FLUSH  = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.check) begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end else begin
                    // preamble value: store only
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                // last pair compare lands this cycle
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.commit   = 1'b1;
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/wpsc_dp.sv =====
// ----------------------------------------------------------------------------
// wpsc_dp
// Datapath of the pair-sum checker: window memory with two read ports,
// pair pointers, 65-bit sum compare, fill tracking and output register.
// ----------------------------------------------------------------------------
module wpsc_dp #(
    parameter int MAX_WINDOW = wpsc_pkg::MAX_WINDOW_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [wpsc_pkg::CFG_W-1:0]   i_cfg_wr_data,
    input  logic [wpsc_pkg::DATA_W-1:0]  i_in_value,
    input  logic                         i_in_seq_start,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [wpsc_pkg::DATA_W-1:0]  o_out_value,
    output logic                         o_out_flag,
    input  wpsc_pkg::t_cmd               i_cmd,
    output wpsc_pkg::t_sts               o_sts
);

    localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int FILL_W = $clog2(MAX_WINDOW + 1);
    localparam int DW     = wpsc_pkg::DATA_W;
    localparam int CW     = wpsc_pkg::LEN_CMP_W;

    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(MAX_WINDOW - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_WINDOW);

    // Circular decrement over the window slots
    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        ptr_dec = (p == '0) ? PTR_LAST : p - PTR_W'(1);
    endfunction

    logic [DW-1:0]                 r_mem [MAX_WINDOW];
    logic [wpsc_pkg::CFG_W-1:0]    r_window_len;
    logic [FILL_W-1:0]             r_fill;
    logic [PTR_W-1:0]              r_slot;
    logic [PTR_W-1:0]              r_pi;
    logic [PTR_W-1:0]              r_pj;
    logic [FILL_W-1:0]             r_i;
    logic [FILL_W-1:0]             r_j;
    logic                          r_rd_vld;
    logic [DW-1:0]                 r_rd_a;
    logic [DW-1:0]                 r_rd_b;
    logic                          r_found;
    logic [DW-1:0]                 r_value;
    logic                          r_out_valid;
    logic [DW-1:0]                 r_out_value;
    logic                          r_out_flag;

    logic [CW-1:0]                 wl_ext;
    logic [FILL_W-1:0]             eff_len;
    logic [FILL_W-1:0]             len_m1;
    logic [FILL_W-1:0]             len_m2;
    logic [DW:0]                   pair_sum;
    logic                          pair_hit;
    logic                          row_end;

    // Effective window length: register saturated to 2..MAX_WINDOW
    assign wl_ext = CW'(r_window_len);
    always_comb begin
        priority if (wl_ext < CW'(wpsc_pkg::MIN_WINDOW)) begin
            eff_len = FILL_W'(wpsc_pkg::MIN_WINDOW);
        end else if (wl_ext > CW'(MAX_WINDOW)) begin
            eff_len = FILL_MAX;
        end else begin
            eff_len = FILL_W'(wl_ext);
        end
    end
    assign len_m1 = eff_len - FILL_W'(1);
    assign len_m2 = eff_len - FILL_W'(2);

    // Exact 65-bit pair sum compare
    assign pair_sum = {r_rd_a[DW-1], r_rd_a} + {r_rd_b[DW-1], r_rd_b};
    assign pair_hit = (pair_sum == {r_value[DW-1], r_value});

    assign row_end  = (r_j == len_m1);

    // Status
    assign o_sts.check     = (r_fill >= eff_len);
    assign o_sts.scan_last = (r_i == len_m2) && row_end;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= wpsc_pkg::WINDOW_LEN_RST;
            r_fill       <= '0;
            r_slot       <= '0;
            r_rd_vld     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_window_len <= i_cfg_wr_data;
            end
            // new sequence clears the fill before the value is looked at
            if (i_cmd.load && i_in_seq_start) begin
                r_fill <= '0;
                r_slot <= '0;
            end else if (i_cmd.commit) begin
                r_slot <= (r_slot == PTR_LAST) ? '0 : r_slot + PTR_W'(1);
                if (r_fill != FILL_MAX) begin
                    r_fill <= r_fill + FILL_W'(1);
                end
            end
            r_rd_vld <= i_cmd.scan_step;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Pair walk: i runs over the newest entries, j over the older ones
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_pi <= ptr_dec(r_slot);
            r_pj <= ptr_dec(ptr_dec(r_slot));
            r_i  <= '0;
            r_j  <= FILL_W'(1);
        end else if (i_cmd.scan_step) begin
            if (row_end) begin
                r_i  <= r_i + FILL_W'(1);
                r_j  <= r_i + FILL_W'(2);
                r_pi <= ptr_dec(r_pi);
                r_pj <= ptr_dec(ptr_dec(r_pi));
            end else begin
                r_j  <= r_j + FILL_W'(1);
                r_pj <= ptr_dec(r_pj);
            end
        end
    end

    // Window memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_mem[r_slot] <= r_value;
        end
        if (i_cmd.scan_step) begin
            r_rd_a <= r_mem[r_pi];
            r_rd_b <= r_mem[r_pj];
        end
    end

    // Match accumulate and payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_found <= 1'b0;
        end else if (r_rd_vld && pair_hit) begin
            r_found <= 1'b1;
        end
        if (i_cmd.load) begin
            r_value <= i_in_value;
        end
        if (i_cmd.out_load) begin
            r_out_value <= r_value;
            r_out_flag  <= r_found;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_out_flag  = r_out_flag;

endmodule

// ===== rtl/window_pair_sum_check.sv =====
// ----------------------------------------------------------------------------
// window_pair_sum_check
// Sliding-window two-sum checker over a stream of signed 64-bit values.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): tdata carries the value, tuser marks the first
//   value of a new sequence. The first L values of a sequence (L = window
//   length register, saturated to 2..MAX_WINDOW) are stored with no result.
//   Every later value gives one output transaction (m_axis): tdata is the
//   value, tuser is 1 when two distinct entries of the last L values sum
//   to it exactly.
//   Timing: a checked value is paced by the pair walk, which reads one pair
//   per cycle from the two read ports of the window memory. One value is
//   processed at a time; s_axis_tready is high only between values.
//   Stall: the result sits in an output register; the next value is
//   accepted while it waits, and that value's result waits in the
//   sequencer until the register is free.
//   Reset: window length returns to 25, fill and write slot clear, no
//   result is pending. Window contents are not cleared; only values of the
//   current sequence are read. Write the window length only while idle.
// ----------------------------------------------------------------------------
module window_pair_sum_check #(
    parameter int MAX_WINDOW = wpsc_pkg::MAX_WINDOW_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration: window length
    input  logic                        i_cfg_wr_en,
    input  logic [wpsc_pkg::CFG_W-1:0]  i_cfg_wr_data,
    // input stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [wpsc_pkg::DATA_W-1:0] s_axis_tdata,   // [63:0] value
    input  logic                        s_axis_tuser,   // [0] seq_start
    // result stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [wpsc_pkg::DATA_W-1:0] m_axis_tdata,   // [63:0] checked_value
    output logic                        m_axis_tuser    // [0] is_pair_sum
);

    wpsc_pkg::t_cmd cmd;
    wpsc_pkg::t_sts sts;

    // Sequencer
    wpsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Window, compare and output register
    wpsc_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_value     (s_axis_tdata),
        .i_in_seq_start (s_axis_tuser),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_out_value    (m_axis_tdata),
        .o_out_flag     (m_axis_tuser),
        .i_cmd          (cmd),
        .o_sts          (sts)
    );

    // Checks
    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted twice in a row");

    a_no_accept_during_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.scan_step |-> !s_axis_tready)
        else $error("input ready while pair walk is running");

    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over a pending output transaction");

    a_commit_not_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> !cmd.scan_step && !cmd.scan_init)
        else $error("window write during pair walk");

endmodule

// ===== dv/window_pair_sum_check_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_pair_sum_check_tb
// Self-checking bench for the sliding-window pair-sum checker. A behavioral
// copy of the window predicts every result at the moment its input
// transaction is taken. A checker process compares each result transaction
// with the oldest prediction. Directed tests cover overflowing sums, equal
// entries, window length saturation and length changes within a sequence.
// Random phases then run well-formed and broken sequences under random
// sender bursts and receiver stalls, then one long receiver hold-off.
// ----------------------------------------------------------------------------
module window_pair_sum_check_tb;

    typedef logic [wpsc_pkg::DATA_W-1:0] t_word;

    typedef struct packed {
        t_word checked_value;
        logic  is_pair_sum;
    } t_window_result;

    localparam int    MAX_WIN         = wpsc_pkg::MAX_WINDOW_DEF;
    localparam t_word VAL_MAX         = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam t_word VAL_MIN         = 64'h8000_0000_0000_0000;
    localparam int    MAX_GAP         = 20;
    localparam int    HOLD_CYCLES     = 400;
    localparam int    SETTLE_CYCLES   = 10;
    // worst checked value: full pair walk plus overhead
    localparam int    MAX_CHECK_CYC   = MAX_WIN * (MAX_WIN - 1) / 2 + 4;
    localparam int    RANDOM_PHASES   = 10;
    localparam int    ITEMS_PER_PHASE = 110;
    // every transaction at the slowest walk, longest gap and long stalls, 4x over
    localparam int    LIMIT_CYCLES    = 1300 * (MAX_CHECK_CYC + MAX_GAP + 200) * 4;

    logic                          i_clk;
    logic                          i_rst_n        = 1'b0;
    logic                          i_cfg_wr_en    = 1'b0;
    logic [wpsc_pkg::CFG_W-1:0]    i_cfg_wr_data  = '0;
    logic                          s_axis_tvalid  = 1'b0;
    logic                          s_axis_tready;
    t_word                         s_axis_tdata   = '0;   // [63:0] value
    logic                          s_axis_tuser   = 1'b0; // [0] seq_start
    logic                          m_axis_tvalid;
    logic                          m_axis_tready  = 1'b0;
    t_word                         m_axis_tdata;          // [63:0] checked_value
    logic                          m_axis_tuser;          // [0] is_pair_sum

    // predictor state
    t_word                      win_vals [MAX_WIN];
    int unsigned                win_fill    = 0;
    int unsigned                win_slot    = 0;
    logic [wpsc_pkg::CFG_W-1:0] win_len_reg = wpsc_pkg::WINDOW_LEN_RST;
    t_window_result             expected_results [$];

    // bookkeeping
    int unsigned mismatch_count  = 0;
    int unsigned values_sent     = 0;
    int unsigned results_checked = 0;
    int unsigned pair_sums_seen  = 0;
    int unsigned cfg_writes      = 0;
    int unsigned cycle_count     = 0;
    int unsigned burst_left      = 0;
    logic        hold_request    = 1'b0;

    window_pair_sum_check #(
        .MAX_WINDOW (MAX_WIN)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, expected_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // window predictor
    // ------------------------------------------------------------------

    // window length register clamped to the usable range
    function automatic int unsigned eff_len();
        int unsigned l;
        l = win_len_reg;
        if (l < wpsc_pkg::MIN_WINDOW) l = wpsc_pkg::MIN_WINDOW;
        if (l > MAX_WIN) l = MAX_WIN;
        return l;
    endfunction

    // slot holding the value k+1 positions back from the write slot
    function automatic int unsigned slot_back(int unsigned k);
        return (win_slot + 2 * MAX_WIN - 1 - k) % MAX_WIN;
    endfunction

    // take one value into the window, queue its result if it gets checked
    function automatic void predict_window_step(t_word v, logic start);
        int unsigned                 len;
        int unsigned                 i;
        int unsigned                 j;
        t_word                       a;
        t_word                       b;
        logic [wpsc_pkg::DATA_W:0]   s;
        t_window_result              r;
        if (start) begin
            win_fill = 0;
            win_slot = 0;
        end
        len = eff_len();
        if (win_fill >= len) begin
            r.checked_value = v;
            r.is_pair_sum   = 1'b0;
            for (i = 0; i < len; i++) begin
                a = win_vals[slot_back(i)];
                for (j = i + 1; j < len; j++) begin
                    b = win_vals[slot_back(j)];
                    // sign-extended to 65 bits, so the sum is exact
                    s = {a[wpsc_pkg::DATA_W-1], a} + {b[wpsc_pkg::DATA_W-1], b};
                    if (s == {v[wpsc_pkg::DATA_W-1], v}) r.is_pair_sum = 1'b1;
                end
            end
            expected_results.insert(expected_results.size(), r);
        end
        win_vals[win_slot] = v;
        win_slot = (win_slot + 1) % MAX_WIN;
        if (win_fill < MAX_WIN) win_fill++;
    endfunction

    // next stimulus value; often a pair sum of the live window when checked
    function automatic t_word pick_value(logic start);
        logic        checked;
        int unsigned len;
        int unsigned i;
        int unsigned j;
        int unsigned r;
        t_word       sum;
        int          sv;
        checked = !start && (win_fill >= eff_len());
        len = eff_len();
        r = checked ? $urandom_range(0, 99) : $urandom_range(55, 99);
        if (r < 55) begin
            i = $urandom_range(0, len - 1);
            j = $urandom_range(0, len - 2);
            if (j >= i) j++;
            sum = win_vals[slot_back(i)] + win_vals[slot_back(j)];
            // near misses just off a real pair sum
            if (r >= 45) sum = $urandom_range(0, 1) ? sum + 1 : sum - 1;
            return sum;
        end else if (r < 72) begin
            sv = int'($urandom_range(0, 80)) - 40;
            return t_word'(longint'(sv));
        end else if (r < 80) begin
            case ($urandom_range(0, 6))
                0: return VAL_MAX;
                1: return VAL_MIN;
                2: return VAL_MAX - 1;
                3: return VAL_MIN + 1;
                4: return '0;
                5: return '1;
                default: return t_word'(1);
            endcase
        end
        return {$urandom(), $urandom()};
    endfunction

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_window_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result transaction: value %h flag %b",
                         $time, m_axis_tdata, m_axis_tuser);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (m_axis_tuser) pair_sums_seen++;
                if (m_axis_tdata !== want.checked_value) begin
                    $display("%0t: checked_value mismatch: expected %h, actual %h",
                             $time, want.checked_value, m_axis_tdata);
                    mismatch_count++;
                end
                if (m_axis_tuser !== want.is_pair_sum) begin
                    $display("%0t: is_pair_sum mismatch for %h: expected %b, actual %b",
                             $time, want.checked_value, want.is_pair_sum, m_axis_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver stall pattern, with a long hold-off on request
    // ------------------------------------------------------------------
    initial begin : rx_stall_gen
        int unsigned mode;
        int unsigned mode_left;
        int unsigned hold_left;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(10, 150);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= ~m_axis_tready;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // offer one transaction and hold it until taken, then predict
    task automatic send_value(input t_word v, input logic start);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tuser  <= start;
        do @(posedge i_clk); while (!s_axis_tready);
        values_sent++;
        predict_window_step(v, start);
    endtask

    // send in bursts with random gaps between them
    task automatic send_item(input t_word v, input logic start);
        int unsigned gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, MAX_GAP);
            burst_left = $urandom_range(1, 40);
            repeat (gap) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
            end
        end
        burst_left--;
        send_value(v, start);
    endtask

    // stop offering, drain every result and let a trailing preamble settle
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_window_len(input logic [wpsc_pkg::CFG_W-1:0] len);
        wait_idle();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= len;
        @(posedge i_clk);
        win_len_reg = len;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // sums that overflow 64 bits must not match their wrapped value
    task automatic test_extreme_sums();
        set_window_len(6'd2);
        send_item(VAL_MAX, 1'b1);
        send_item(VAL_MAX, 1'b0);
        send_item(t_word'(-64'sd2), 1'b0);
        send_item(VAL_MIN, 1'b1);
        send_item(VAL_MIN, 1'b0);
        send_item('0, 1'b0);
        send_item(VAL_MIN, 1'b1);
        send_item(VAL_MAX, 1'b0);
        send_item('1, 1'b0);
        send_item(VAL_MAX - 1, 1'b0);
    endtask

    // two equal values at different slots form a pair
    task automatic test_equal_entries();
        set_window_len(6'd2);
        send_item(t_word'(5), 1'b1);
        send_item(t_word'(5), 1'b0);
        send_item(t_word'(10), 1'b0);
    endtask

    // lengths below the minimum act as the minimum
    task automatic test_length_saturation();
        set_window_len(6'd0);
        send_item(t_word'(3), 1'b1);
        send_item(t_word'(4), 1'b0);
        send_item(t_word'(7), 1'b0);
        set_window_len(6'd1);
        send_item(t_word'(-64'sd3), 1'b1);
        send_item(t_word'(-64'sd4), 1'b0);
        send_item(t_word'(-64'sd7), 1'b0);
    endtask

    // grow the window mid-sequence (back to preamble), then shrink it
    task automatic test_length_change();
        set_window_len(6'd3);
        send_item(t_word'(1), 1'b1);
        send_item(t_word'(2), 1'b0);
        send_item(t_word'(4), 1'b0);
        send_item(t_word'(3), 1'b0);
        set_window_len(6'd5);
        send_item(t_word'(6), 1'b0);
        send_item(t_word'(7), 1'b0);
        set_window_len(6'd2);
        send_item(t_word'(13), 1'b0);
    endtask

    // phases of random sequences, each phase at its own window length
    task automatic test_random_sequences();
        int unsigned                p;
        int unsigned                k;
        int unsigned                len;
        int unsigned                sent;
        int unsigned                seq_len;
        logic                       start;
        logic [wpsc_pkg::CFG_W-1:0] cfg;
        for (p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: cfg = 6'd32;
                1: cfg = 6'd63;
                2: cfg = 6'd2;
                3: cfg = 6'($urandom_range(33, 62));
                4: cfg = 6'($urandom_range(9, 31));
                default: cfg = 6'($urandom_range(0, 12));
            endcase
            set_window_len(cfg);
            len  = eff_len();
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                // mostly full sequences, some cut off inside the preamble
                if ($urandom_range(0, 99) < 85)
                    seq_len = len + $urandom_range(1, 2 * len + 20);
                else
                    seq_len = $urandom_range(1, len);
                for (k = 0; (k < seq_len) && (sent < ITEMS_PER_PHASE); k++) begin
                    start = (k == 0) || ($urandom_range(0, 99) < 2);
                    send_item(pick_value(start), start);
                    sent++;
                end
            end
        end
    endtask

    // receiver holds off while the sender keeps offering back to back
    task automatic test_output_pressure();
        int unsigned k;
        set_window_len(6'd2);
        hold_request = 1'b1;
        for (k = 0; k < 40; k++)
            send_value(pick_value(k == 0), k == 0);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_extreme_sums();
        test_equal_entries();
        test_length_saturation();
        test_length_change();
        test_random_sequences();
        test_output_pressure();

        wait_idle();
        repeat (MAX_CHECK_CYC + 20) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived",
                     $time, expected_results.size());
            mismatch_count++;
        end

        $display("Run covered %0d input transactions over %0d window length writes,",
                 values_sent, cfg_writes);
        $display("with %0d results compared (%0d pair sums), %0d mismatches.",
                 results_checked, pair_sums_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/wpsc_pkg.sv
rtl/wpsc_ctrl.sv
rtl/wpsc_dp.sv
rtl/window_pair_sum_check.sv
dv/window_pair_sum_check_tb.sv
